>>> rtl/core/cgm_pkg.sv
// shared types and constants for the color gradient max channel core
package cgm_pkg;

   localparam int PIX_W   = 24;
   localparam int CH_W    = 8;
   localparam int GRAD_W  = 9;
   localparam int SQ_W    = 17;
   localparam int RAD_W   = 25;
   localparam int ROOT_W  = 13;
   localparam int COORD_W = 11;
   localparam int CFG_W   = 12;
   localparam int STEP_W  = 4;
   localparam logic [STEP_W-1:0] ROOT_LAST_STEP = 4'd12;
   localparam logic [RAD_W-1:0]  ROOT_FIRST_BIT = 25'h1000000;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      JOB_ABOVE = 2'd0,
      JOB_LEFT  = 2'd1,
      JOB_CORNER = 2'd2
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_NEXT,
      ST_MERGE,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic [SQ_W-1:0]   sq;
      logic [GRAD_W-1:0] gx;
      logic [GRAD_W-1:0] gy;
   } lane_out_type;

endpackage

>>> rtl/core/cgm_ram.sv
// generic single write port ram with registered read
module cgm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/cgm_lane.sv
// one color channel: gradients and squared magnitude
module cgm_lane (
   input  logic [cgm_pkg::CH_W-1:0] xp,
   input  logic [cgm_pkg::CH_W-1:0] xm,
   input  logic [cgm_pkg::CH_W-1:0] yp,
   input  logic [cgm_pkg::CH_W-1:0] ym,
   input  logic                     hx,
   input  logic                     hy,
   output cgm_pkg::lane_out_type    result
);

   logic signed [cgm_pkg::GRAD_W-1:0]   gx;
   logic signed [cgm_pkg::GRAD_W-1:0]   gy;
   logic signed [2*cgm_pkg::GRAD_W-1:0] px;
   logic signed [2*cgm_pkg::GRAD_W-1:0] py;

   always_comb begin
      gx = hx ? ($signed({1'b0, xp}) - $signed({1'b0, xm})) : '0;
      gy = hy ? ($signed({1'b0, yp}) - $signed({1'b0, ym})) : '0;
      px = gx * gx;
      py = gy * gy;
      result.sq = {1'b0, px[15:0]} + {1'b0, py[15:0]};
      result.gx = gx;
      result.gy = gy;
   end

endmodule

>>> rtl/core/cgm_merge.sv
// picks the channel with the largest squared gradient, ties to lower channel
module cgm_merge (
   input  logic                  clock,
   input  logic                  en,
   input  cgm_pkg::lane_out_type lane_b,
   input  cgm_pkg::lane_out_type lane_g,
   input  cgm_pkg::lane_out_type lane_r,
   output cgm_pkg::lane_out_type winner
);

   cgm_pkg::lane_out_type win_ff;
   cgm_pkg::lane_out_type win_in;

   always_comb begin
      if (lane_b.sq >= lane_g.sq && lane_b.sq >= lane_r.sq) begin
         win_in = lane_b;
      end else if (lane_g.sq >= lane_r.sq) begin
         win_in = lane_g;
      end else begin
         win_in = lane_r;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         win_ff <= win_in;
      end
   end

   assign winner = win_ff;

endmodule

>>> rtl/core/cgm_isqrt.sv
// iterative integer square root, one result bit per cycle
module cgm_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cgm_pkg::RAD_W-1:0]  radicand,
   output logic                       done,
   output logic [cgm_pkg::ROOT_W-1:0] root
);

   logic [cgm_pkg::RAD_W-1:0]  rem_ff;
   logic [cgm_pkg::RAD_W-1:0]  res_ff;
   logic [cgm_pkg::RAD_W-1:0]  bit_ff;
   logic [cgm_pkg::STEP_W-1:0] step_ff;
   logic                       busy_ff;
   logic                       done_ff;
   logic [cgm_pkg::RAD_W-1:0]  trial;

   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= radicand;
            res_ff  <= '0;
            bit_ff  <= cgm_pkg::ROOT_FIRST_BIT;
            step_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (rem_ff >= trial) begin
               rem_ff <= rem_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff  <= bit_ff >> 2;
            step_ff <= step_ff + 1'b1;
            if (step_ff == cgm_pkg::ROOT_LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = res_ff[cgm_pkg::ROOT_W-1:0];

endmodule

>>> rtl/core/color_gradient_max_channel_core.sv
// Color gradient max channel core.
// req_* takes BGR raster pixels; a transaction is taken when tvalid and tready
// are high. rsp_* gives results (row, col, magnitude, dx, dy) with tlast on the
// final result of the frame. csr_* writes image_width (index 0) and
// image_height (index 1); any write restarts the frame at row 0, column 0.
// Both line buffers are read in the accept cycle and in the cycle after it, and
// written in ST_RD_B, which follows ST_RD_A. Each result then passes through job
// select (ST_NEXT), lanes and merge (ST_MERGE), square root start (ST_ROOT_GO)
// and run (ST_ROOT_WAIT), and the output register (ST_SEND), where rsp_tvalid is high.
// A pixel gives 0 to 3 results: none on row 0, one on middle rows, up to three
// on the last row. req_tready is high only when the core is idle, so a new pixel
// is taken only after every result of the last one has been sent.
// When rsp_tready is low the result holds and no new pixel is taken.
// Reset sets width 640, height 480 and the frame position to the start;
// line buffer contents are not cleared and need no clearing pass.
module color_gradient_max_channel_core #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [23:0]               req_tdata,  // blue, green, red
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [55:0]               rsp_tdata,  // row, col, magnitude, dominant_dx, dominant_dy
   output logic                      rsp_tlast,  // frame_last
   input  logic                      csr_we,
   input  logic                      csr_addr,
   input  logic [cgm_pkg::CFG_W-1:0] csr_wdata
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CWW = (WW > cgm_pkg::CFG_W) ? WW : cgm_pkg::CFG_W;
   localparam int CWH = (HW > cgm_pkg::CFG_W) ? HW : cgm_pkg::CFG_W;

   cgm_pkg::state_type state_ff, state_in;

   logic [cgm_pkg::CFG_W-1:0] width_ff;
   logic [cgm_pkg::CFG_W-1:0] height_ff;
   logic [WW-1:0]             col_cnt_ff;
   logic [HW-1:0]             row_cnt_ff;
   logic [WW-1:0]             c_ff;
   logic [HW-1:0]             r_ff;
   logic [cgm_pkg::PIX_W-1:0] cur_ff;
   logic [cgm_pkg::PIX_W-1:0] right_ff;
   logic [cgm_pkg::PIX_W-1:0] up2_ff;
   logic [cgm_pkg::PIX_W-1:0] win0_ff;
   logic [cgm_pkg::PIX_W-1:0] win1_ff;
   logic [cgm_pkg::PIX_W-1:0] win2_ff;
   logic [cgm_pkg::PIX_W-1:0] xm_above_ff;
   logic [cgm_pkg::PIX_W-1:0] xm_left_ff;
   logic                      hx_above_ff;
   logic                      hy_above_ff;
   logic                      hx_left_ff;
   logic [2:0]                pend_ff;
   cgm_pkg::job_type          job_ff;

   logic [cgm_pkg::COORD_W-1:0] out_row_ff;
   logic [cgm_pkg::COORD_W-1:0] out_col_ff;
   logic [cgm_pkg::ROOT_W-1:0]  out_mag_ff;
   logic [cgm_pkg::GRAD_W-1:0]  out_dx_ff;
   logic [cgm_pkg::GRAD_W-1:0]  out_dy_ff;
   logic                        out_last_ff;

   logic [CWW-1:0] wext;
   logic [CWH-1:0] hext;
   logic [WW-1:0]  w_eff;
   logic [HW-1:0]  h_eff;
   logic [WW-1:0]  c_start;
   logic [HW-1:0]  r_start;
   logic [WW:0]    c_next;
   logic [HW:0]    r_next;
   logic           hx_above;
   logic           last_row;

   logic [AW-1:0]             lp_raddr;
   logic [AW-1:0]             lp2_raddr;
   logic                      ram_we;
   logic [cgm_pkg::PIX_W-1:0] lp_rdata;
   logic [cgm_pkg::PIX_W-1:0] lp2_rdata;

   logic [cgm_pkg::PIX_W-1:0] sel_xp;
   logic [cgm_pkg::PIX_W-1:0] sel_xm;
   logic [cgm_pkg::PIX_W-1:0] sel_yp;
   logic [cgm_pkg::PIX_W-1:0] sel_ym;
   logic                      sel_hx;
   logic                      sel_hy;
   cgm_pkg::lane_out_type     lane_res [3];
   cgm_pkg::lane_out_type     winner;
   logic                      merge_en;
   logic                      root_start;
   logic                      root_done;
   logic [cgm_pkg::ROOT_W-1:0] root;

   always_comb begin
      wext = CWW'(width_ff);
      hext = CWH'(height_ff);
      if (wext < CWW'(3)) begin
         w_eff = WW'(3);
      end else if (wext > CWW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(wext);
      end
      if (hext < CWH'(3)) begin
         h_eff = HW'(3);
      end else if (hext > CWH'(MAX_HEIGHT)) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(hext);
      end
      if (row_cnt_ff >= h_eff || col_cnt_ff >= w_eff) begin
         c_start = '0;
         r_start = '0;
      end else begin
         c_start = col_cnt_ff;
         r_start = row_cnt_ff;
      end
      c_next   = {1'b0, c_ff} + 1'b1;
      r_next   = {1'b0, r_ff} + 1'b1;
      hx_above = (c_ff != '0) && (c_next < {1'b0, w_eff});
      last_row = (r_next == {1'b0, h_eff});
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cgm_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = cgm_pkg::ST_RD_A;
            end
         end
         cgm_pkg::ST_RD_A: state_in = cgm_pkg::ST_RD_B;
         cgm_pkg::ST_RD_B: state_in = cgm_pkg::ST_NEXT;
         cgm_pkg::ST_NEXT: begin
            if (pend_ff == '0) begin
               state_in = cgm_pkg::ST_IDLE;
            end else begin
               state_in = cgm_pkg::ST_MERGE;
            end
         end
         cgm_pkg::ST_MERGE: state_in = cgm_pkg::ST_ROOT_GO;
         cgm_pkg::ST_ROOT_GO: state_in = cgm_pkg::ST_ROOT_WAIT;
         cgm_pkg::ST_ROOT_WAIT: begin
            if (root_done) begin
               state_in = cgm_pkg::ST_SEND;
            end
         end
         cgm_pkg::ST_SEND: begin
            if (rsp_tready) begin
               state_in = cgm_pkg::ST_NEXT;
            end
         end
         default: state_in = cgm_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      ram_we     = 1'b0;
      merge_en   = 1'b0;
      root_start = 1'b0;
      lp_raddr   = c_ff[AW-1:0];
      lp2_raddr  = c_ff[AW-1:0];
      case (state_ff)
         cgm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            lp_raddr   = AW'(c_start + 1'b1);
            lp2_raddr  = c_start[AW-1:0];
         end
         cgm_pkg::ST_RD_B:    ram_we     = 1'b1;
         cgm_pkg::ST_MERGE:   merge_en   = 1'b1;
         cgm_pkg::ST_ROOT_GO: root_start = 1'b1;
         cgm_pkg::ST_SEND:    rsp_tvalid = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= cgm_pkg::ST_IDLE;
         width_ff   <= 12'd640;
         height_ff  <= 12'd480;
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
         pend_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            if (csr_addr == cgm_pkg::REG_WIDTH) begin
               width_ff <= csr_wdata;
            end else begin
               height_ff <= csr_wdata;
            end
            col_cnt_ff <= '0;
            row_cnt_ff <= '0;
         end else if (state_ff == cgm_pkg::ST_RD_B) begin
            if (c_next >= {1'b0, w_eff}) begin
               col_cnt_ff <= '0;
               if (r_next >= {1'b0, h_eff}) begin
                  row_cnt_ff <= '0;
               end else begin
                  row_cnt_ff <= r_next[HW-1:0];
               end
            end else begin
               col_cnt_ff <= c_next[WW-1:0];
               row_cnt_ff <= r_ff;
            end
         end
         if (state_ff == cgm_pkg::ST_RD_B) begin
            pend_ff[cgm_pkg::JOB_ABOVE]  <= (r_ff != '0);
            pend_ff[cgm_pkg::JOB_LEFT]   <= last_row && (c_ff != '0);
            pend_ff[cgm_pkg::JOB_CORNER] <= last_row && (c_next == {1'b0, w_eff});
         end else if (state_ff == cgm_pkg::ST_SEND && rsp_tready) begin
            pend_ff[job_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == cgm_pkg::ST_IDLE && req_tvalid) begin
         cur_ff <= req_tdata;
         c_ff   <= c_start;
         r_ff   <= r_start;
      end
      if (state_ff == cgm_pkg::ST_RD_A) begin
         right_ff <= lp_rdata;
         up2_ff   <= lp2_rdata;
      end
      if (state_ff == cgm_pkg::ST_RD_B) begin
         xm_above_ff <= win0_ff;
         xm_left_ff  <= win2_ff;
         hx_above_ff <= hx_above;
         hy_above_ff <= (r_ff > HW'(1));
         hx_left_ff  <= (c_ff > WW'(1));
         win0_ff     <= lp_rdata;
         win1_ff     <= cur_ff;
         win2_ff     <= win1_ff;
      end
      if (state_ff == cgm_pkg::ST_NEXT) begin
         if (pend_ff[cgm_pkg::JOB_ABOVE]) begin
            job_ff <= cgm_pkg::JOB_ABOVE;
         end else if (pend_ff[cgm_pkg::JOB_LEFT]) begin
            job_ff <= cgm_pkg::JOB_LEFT;
         end else begin
            job_ff <= cgm_pkg::JOB_CORNER;
         end
      end
      if (state_ff == cgm_pkg::ST_ROOT_WAIT && root_done) begin
         out_mag_ff  <= root;
         out_dx_ff   <= winner.gx;
         out_dy_ff   <= winner.gy;
         out_last_ff <= (job_ff == cgm_pkg::JOB_CORNER);
         case (job_ff)
            cgm_pkg::JOB_ABOVE: begin
               out_row_ff <= cgm_pkg::COORD_W'(r_ff - 1'b1);
               out_col_ff <= cgm_pkg::COORD_W'(c_ff);
            end
            cgm_pkg::JOB_LEFT: begin
               out_row_ff <= cgm_pkg::COORD_W'(r_ff);
               out_col_ff <= cgm_pkg::COORD_W'(c_ff - 1'b1);
            end
            default: begin
               out_row_ff <= cgm_pkg::COORD_W'(r_ff);
               out_col_ff <= cgm_pkg::COORD_W'(c_ff);
            end
         endcase
      end
   end

   cgm_ram #(.WIDTH(cgm_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line_prev (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (c_ff[AW-1:0]),
      .wr_data (cur_ff),
      .rd_addr (lp_raddr),
      .rd_data (lp_rdata)
   );

   cgm_ram #(.WIDTH(cgm_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_line_prev2 (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (c_ff[AW-1:0]),
      .wr_data (lp_rdata),
      .rd_addr (lp2_raddr),
      .rd_data (lp2_rdata)
   );

   always_comb begin
      case (job_ff)
         cgm_pkg::JOB_ABOVE: begin
            sel_xp = right_ff;
            sel_xm = xm_above_ff;
            sel_yp = cur_ff;
            sel_ym = up2_ff;
            sel_hx = hx_above_ff;
            sel_hy = hy_above_ff;
         end
         cgm_pkg::JOB_LEFT: begin
            sel_xp = cur_ff;
            sel_xm = xm_left_ff;
            sel_yp = '0;
            sel_ym = '0;
            sel_hx = hx_left_ff;
            sel_hy = 1'b0;
         end
         default: begin
            sel_xp = '0;
            sel_xm = '0;
            sel_yp = '0;
            sel_ym = '0;
            sel_hx = 1'b0;
            sel_hy = 1'b0;
         end
      endcase
   end

   for (genvar k = 0; k < 3; k++) begin : g_lane
      cgm_lane u_lane (
         .xp     (sel_xp[k*cgm_pkg::CH_W +: cgm_pkg::CH_W]),
         .xm     (sel_xm[k*cgm_pkg::CH_W +: cgm_pkg::CH_W]),
         .yp     (sel_yp[k*cgm_pkg::CH_W +: cgm_pkg::CH_W]),
         .ym     (sel_ym[k*cgm_pkg::CH_W +: cgm_pkg::CH_W]),
         .hx     (sel_hx),
         .hy     (sel_hy),
         .result (lane_res[k])
      );
   end

   cgm_merge u_merge (
      .clock  (clock),
      .en     (merge_en),
      .lane_b (lane_res[0]),
      .lane_g (lane_res[1]),
      .lane_r (lane_res[2]),
      .winner (winner)
   );

   cgm_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand ({winner.sq, 8'd0}),
      .done     (root_done),
      .root     (root)
   );

   assign rsp_tdata = {3'd0, out_dy_ff, out_dx_ff, out_mag_ff, out_col_ff, out_row_ff};
   assign rsp_tlast = out_last_ff;

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result is pending");

   a_root_when_waiting: assert property (@(posedge clock) disable iff (reset)
      root_done |-> state_ff == cgm_pkg::ST_ROOT_WAIT)
      else $error("square root finished outside its wait state");

   a_corner_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> out_mag_ff == '0 && out_dx_ff == '0 && out_dy_ff == '0)
      else $error("frame corner result is not zero");
`endif

endmodule

>>> tb/sv/testbench.sv
// testbench for the color gradient max channel core: directed and random raster frames checked against a predictor
`timescale 1ns / 1ps

module testbench;

   typedef struct packed {
      logic [10:0] row;
      logic [10:0] col;
      logic [12:0] mag;
      logic [8:0]  dx;
      logic [8:0]  dy;
      logic        last;
   } grad_result_type;

   class gradient_scoreboard;
      int unsigned width_reg = 640, height_reg = 480;
      logic [23:0] above_line [2048];
      logic [23:0] above2_line [2048];
      logic [23:0] win [3];
      int unsigned row_pos, col_pos;
      grad_result_type pending [$];
      int errors;

      function int unsigned clamp(int unsigned v);
         if (v < 3) return 3;
         if (v > 2048) return 2048;
         return v;
      endfunction

      function void set_reg(logic idx, int unsigned v);
         if (idx == cgm_pkg::REG_WIDTH) width_reg = v;
         else height_reg = v;
         row_pos = 0;
         col_pos = 0;
      endfunction

      function int unsigned int_root(int unsigned v);
         int unsigned res, b;
         res = 0;
         b = 1 << 30;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      function void add_result(int unsigned r, int unsigned c, bit hx, logic [23:0] xp,
                               logic [23:0] xm, bit hy, logic [23:0] yp, logic [23:0] ym,
                               bit last);
         int gx [3];
         int gy [3];
         int s [3];
         int w;
         grad_result_type g;
         for (int k = 0; k < 3; k++) begin
            gx[k] = hx ? int'(xp[8*k +: 8]) - int'(xm[8*k +: 8]) : 0;
            gy[k] = hy ? int'(yp[8*k +: 8]) - int'(ym[8*k +: 8]) : 0;
            s[k] = gx[k] * gx[k] + gy[k] * gy[k];
         end
         if (s[0] >= s[1] && s[0] >= s[2]) w = 0;
         else if (s[1] >= s[2]) w = 1;
         else w = 2;
         g.row = r[10:0];
         g.col = c[10:0];
         g.mag = 13'(int_root(s[w] * 256));
         g.dx = 9'(gx[w]);
         g.dy = 9'(gy[w]);
         g.last = last;
         pending.push_back(g);
      endfunction

      function void note_pixel(logic [23:0] px);
         int unsigned w, h, r, c;
         bit hx;
         w = clamp(width_reg);
         h = clamp(height_reg);
         r = row_pos;
         c = col_pos;
         if (r >= h || c >= w) begin
            r = 0;
            c = 0;
         end
         if (r >= 1) begin
            hx = (c >= 1 && c + 2 <= w);
            add_result(r - 1, c, hx, hx ? above_line[c + 1] : 24'd0, win[0],
                       r >= 2, px, above2_line[c], 0);
         end
         if (r == h - 1) begin
            if (c >= 1) add_result(r, c - 1, c >= 2, px, win[2], 0, 0, 0, 0);
            if (c == w - 1) add_result(r, c, 0, 0, 0, 0, 0, 0, 1);
         end
         win[2] = win[1];
         win[1] = px;
         win[0] = above_line[c];
         above2_line[c] = above_line[c];
         above_line[c] = px;
         c++;
         if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
         end
         row_pos = r;
         col_pos = c;
      endfunction

      function void check_result(grad_result_type got);
         grad_result_type exp_r;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (got.row != exp_r.row || got.col != exp_r.col || got.mag != exp_r.mag ||
             got.dx != exp_r.dx || got.dy != exp_r.dy || got.last != exp_r.last) begin
            $display("%0t: mismatch expected row %0d col %0d mag %0d dx %h dy %h last %b",
                     $time, exp_r.row, exp_r.col, exp_r.mag, exp_r.dx, exp_r.dy, exp_r.last);
            $display("%0t:          actual row %0d col %0d mag %0d dx %h dy %h last %b",
                     $time, got.row, got.col, got.mag, got.dx, got.dy, got.last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [23:0] req_tdata = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_we = 0;
   logic csr_addr = 0;
   logic [cgm_pkg::CFG_W-1:0] csr_wdata = 0;

   gradient_scoreboard sb;
   int send_idle_pct, recv_idle_pct;
   longint cycles;

   color_gradient_max_channel_core uut (.*);

   initial forever #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("color_gradient_max_channel_core verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result({rsp_tdata[10:0], rsp_tdata[21:11], rsp_tdata[34:22],
                          rsp_tdata[43:35], rsp_tdata[52:44], rsp_tlast});
      if (reset) rsp_tready <= 0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic write_reg(logic idx, logic [cgm_pkg::CFG_W-1:0] v);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      sb.set_reg(idx, v);
      @(posedge clock);
   endtask

   task automatic send_pixel(logic [23:0] px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= px;
      do @(posedge clock); while (!req_tready);
      sb.note_pixel(px);
   endtask

   task automatic drain;
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_pixel(int mode);
      case (mode)
         0: return 24'($urandom);
         1: return {3{8'($urandom_range(1) ? 8'hff : 8'h00)}} ^ 24'($urandom_range(7) << 8);
         default: return {$urandom_range(1) ? 8'hff : 8'h00, 8'($urandom),
                          $urandom_range(1) ? 8'hff : 8'h00};
      endcase
   endfunction

   task automatic send_frame(int w, int h, int mode);
      for (int i = 0; i < w * h; i++) send_pixel(rand_pixel(mode));
   endtask

   initial begin
      sb = new();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      cycles = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: minimum frame with extremes, ties and clamped sizes
      write_reg(cgm_pkg::REG_WIDTH, 0);
      write_reg(cgm_pkg::REG_HEIGHT, 1);
      for (int i = 0; i < 9; i++) send_pixel(i % 2 ? 24'hffffff : 24'h000000);
      for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 24'h000000 : 24'hffffff);
      drain();
      write_reg(cgm_pkg::REG_WIDTH, 4);
      write_reg(cgm_pkg::REG_HEIGHT, 3);
      send_pixel(24'h123456);
      send_pixel(24'h654321);
      drain();
      // restart mid-frame by writing, then random frames under three idling patterns
      write_reg(cgm_pkg::REG_HEIGHT, 3);
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 65 : 0;
         recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 34 : 0;
         for (int f = 0; f < 3; f++) begin
            int w, h;
            w = $urandom_range(3, 6);
            h = $urandom_range(3, 5);
            write_reg(cgm_pkg::REG_WIDTH, cgm_pkg::CFG_W'(w));
            write_reg(cgm_pkg::REG_HEIGHT, cgm_pkg::CFG_W'(h));
            send_frame(w, h, $urandom_range(2));
            drain();
         end
      end
      // width above the maximum: a partial first row, no results expected
      write_reg(cgm_pkg::REG_WIDTH, 12'hfff);
      write_reg(cgm_pkg::REG_HEIGHT, 3);
      for (int i = 0; i < 10; i++) send_pixel(24'($urandom));
      drain();
      // height above the maximum with the narrowest width
      write_reg(cgm_pkg::REG_WIDTH, 3);
      write_reg(cgm_pkg::REG_HEIGHT, 12'hfff);
      for (int i = 0; i < 10; i++) send_pixel(24'($urandom));
      drain();
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("color_gradient_max_channel_core verification clean");
      end else begin
         $display("color_gradient_max_channel_core verification failed");
      end
      $finish;
   end
endmodule
